// File: rtl/kwm_pkg.sv
// Shared types and codes for the k-way sorted merge core.
package kwm_pkg;

  localparam int unsigned IDX_W    = 3;
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned STATUS_W = 2;

  // Operation codes of an input beat.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  // Status codes of a result beat.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                      operation;
    logic [IDX_W-1:0]          list_index;
    logic signed [FIELD_W-1:0] item_value;
  } kwm_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] merged_value;
    logic [IDX_W-1:0]          source_list;
    logic [STATUS_W-1:0]       status;
  } kwm_out_t;

endpackage

// File: rtl/kwm_store.sv
// Value store for all lists: one write port, one registered read port.
module kwm_store #(
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned ADDR_W = 9,
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/kwm_cmp.sv
// Shared signed comparator that keeps the smallest head seen during a scan.
module kwm_cmp #(
  parameter int unsigned VALUE_W = 32,
  parameter int unsigned LIDX_W  = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clear,
  input  logic               cand_valid,
  input  logic [VALUE_W-1:0] cand_value,
  input  logic [LIDX_W-1:0]  cand_index,
  output logic               best_valid,
  output logic [VALUE_W-1:0] best_value,
  output logic [LIDX_W-1:0]  best_index
);

  logic               best_valid_r;
  logic [VALUE_W-1:0] best_value_r;
  logic [LIDX_W-1:0]  best_index_r;
  logic               take_cand;

  // Lists are scanned in rising order, so "less or equal" lets the
  // highest list index win a tie.
  assign take_cand = cand_valid &&
                     (!best_valid_r || ($signed(cand_value) <= $signed(best_value_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
    end else if (clear) begin
      best_valid_r <= 1'b0;
    end else if (take_cand) begin
      best_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!clear && take_cand) begin
      best_value_r <= cand_value;
      best_index_r <= cand_index;
    end
  end

  assign best_valid = best_valid_r;
  assign best_value = best_value_r;
  assign best_index = best_index_r;

endmodule

// File: rtl/k_way_sorted_merge_core.sv
// Top level of the k-way sorted merge core: sequencer, list pointers and output register.
// Keeps LIST_COUNT FIFO lists of LIST_DEPTH signed values each. A push beat appends a
// value to one list in the PUSH state, which registers its result once the output register
// is free. A take beat visits the lists one per cycle through the single read port of the
// value store and one shared comparator, then removes the winning head: it passes through
// the SCAN, DRAIN and SEL states, and the DONE state registers its result and returns the
// sequencer to idle once the output register is free. Input is accepted only while the
// sequencer is idle; a finished result sits in the output register until taken, and a
// new beat can be accepted meanwhile, but its own result waits for that register to
// drain. No clearing pass is needed after reset.
module k_way_sorted_merge_core
  import kwm_pkg::*;
#(
  parameter int unsigned LIST_COUNT  = 8,
  parameter int unsigned LIST_DEPTH  = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  kwm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output kwm_out_t out_data
);

  localparam int unsigned LIDX_W    = $clog2(LIST_COUNT);
  localparam int unsigned PTR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(LIST_DEPTH + 1);
  localparam int unsigned MEM_DEPTH = LIST_COUNT * LIST_DEPTH;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
  localparam int unsigned CHK_W     = 7;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PUSH  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_SEL   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]             state_r, state_nxt;
  logic [LIDX_W-1:0]      cur_r;
  logic [ADDR_W-1:0]      base_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic                   idx_ok_r;
  logic                   rd_pend_r;
  logic [LIDX_W-1:0]      rd_idx_r;
  logic [PTR_W-1:0]       rptr_r [LIST_COUNT];
  logic [CNT_W-1:0]       fill_r [LIST_COUNT];
  logic                   out_valid_r;
  kwm_out_t               out_data_r;

  logic                   accept;
  logic                   emit_ok;
  logic                   last_list;
  logic [PTR_W-1:0]       cur_rptr;
  logic [CNT_W-1:0]       cur_fill;
  logic [PTR_W-1:0]       rptr_inc;
  logic [CNT_W:0]         pos_sum;
  logic [PTR_W-1:0]       tail_pos;
  logic                   push_ok;
  logic                   wr_en;
  logic                   rd_en;
  logic [VALUE_WIDTH-1:0] rd_data;
  logic                   best_valid;
  logic [VALUE_WIDTH-1:0] best_value;
  logic [LIDX_W-1:0]      best_index;
  logic                   cmp_clear;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign emit_ok   = !out_valid_r || out_ready;
  assign last_list = (cur_r == LIDX_W'(LIST_COUNT - 1));

  // Every pointer and count read goes through the one list index in cur_r.
  assign cur_rptr = rptr_r[cur_r];
  assign cur_fill = fill_r[cur_r];
  assign rptr_inc = (cur_rptr == PTR_W'(LIST_DEPTH - 1)) ? '0 : cur_rptr + 1'b1;
  assign pos_sum  = (CNT_W+1)'(cur_rptr) + (CNT_W+1)'(cur_fill);
  assign tail_pos = (pos_sum >= (CNT_W+1)'(LIST_DEPTH)) ?
                    PTR_W'(pos_sum - (CNT_W+1)'(LIST_DEPTH)) : PTR_W'(pos_sum);
  assign push_ok  = idx_ok_r && (cur_fill < CNT_W'(LIST_DEPTH));

  assign wr_en     = (state_r == S_PUSH) && emit_ok && push_ok;
  assign rd_en     = (state_r == S_SCAN) && (cur_fill != '0);
  assign cmp_clear = accept;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_data.operation == OP_TAKE) ? S_SCAN : S_PUSH;
        end
      end
      S_PUSH: begin
        if (emit_ok) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (last_list) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_SEL;
      S_SEL:   state_nxt = S_DONE;
      S_DONE: begin
        if (emit_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cur_r;
    if (accept) begin
      val_r    <= VALUE_WIDTH'($unsigned(in_data.item_value));
      idx_ok_r <= (CHK_W'(in_data.list_index) < CHK_W'(LIST_COUNT));
      if (in_data.operation == OP_TAKE) begin
        cur_r  <= '0;
        base_r <= '0;
      end else begin
        cur_r  <= LIDX_W'(in_data.list_index);
        base_r <= ADDR_W'(LIDX_W'(in_data.list_index) * LIST_DEPTH);
      end
    end else if (state_r == S_SCAN) begin
      cur_r  <= cur_r + 1'b1;
      base_r <= base_r + ADDR_W'(LIST_DEPTH);
    end else if (state_r == S_SEL) begin
      cur_r <= best_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LIST_COUNT; i++) begin
        rptr_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else if (wr_en) begin
      fill_r[cur_r] <= cur_fill + 1'b1;
    end else if ((state_r == S_DONE) && emit_ok && best_valid) begin
      rptr_r[cur_r] <= rptr_inc;
      fill_r[cur_r] <= cur_fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (((state_r == S_PUSH) || (state_r == S_DONE)) && emit_ok) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_PUSH) && emit_ok) begin
      out_data_r.merged_value <= '0;
      out_data_r.source_list  <= '0;
      out_data_r.status       <= push_ok ? ST_OK : ST_FULL;
    end else if ((state_r == S_DONE) && emit_ok) begin
      if (best_valid) begin
        out_data_r.merged_value <= FIELD_W'($unsigned(best_value));
        out_data_r.source_list  <= IDX_W'(best_index);
        out_data_r.status       <= ST_OK;
      end else begin
        out_data_r.merged_value <= '0;
        out_data_r.source_list  <= '0;
        out_data_r.status       <= ST_EMPTY;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  kwm_store #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (VALUE_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (base_r + ADDR_W'(tail_pos)),
    .wr_data (val_r),
    .rd_en   (rd_en),
    .rd_addr (base_r + ADDR_W'(cur_rptr)),
    .rd_data (rd_data)
  );

  kwm_cmp #(
    .VALUE_W (VALUE_WIDTH),
    .LIDX_W  (LIDX_W)
  ) u_cmp (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (cmp_clear),
    .cand_valid (rd_pend_r),
    .cand_value (rd_data),
    .cand_index (rd_idx_r),
    .best_valid (best_valid),
    .best_value (best_value),
    .best_index (best_index)
  );

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH) |-> (cur_fill <= CNT_W'(LIST_DEPTH)))
    else $error("list fill count exceeds the list depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("sequencer stayed idle after accepting a beat");

  a_no_read_of_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && (cur_fill == '0)) |=> !rd_pend_r)
    else $error("store read issued for an empty list");

  a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == ST_EMPTY)) |->
      ((out_data_r.merged_value == '0) && (out_data_r.source_list == '0)))
    else $error("empty take result carries a nonzero payload");

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the k-way sorted merge core: ordered pushes, takes and noise.
module tb_top
  import kwm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_COUNT   = 8;
  localparam int LIST_DEPTH   = 64;
  localparam int RANDOM_BEATS = 440;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;

  // Idle percentages per phase: none, sender idle, receiver stalling, both.
  localparam int SEND_IDLE_PCT [4] = '{0, 84, 0, 21};
  localparam int RECV_STALL_PCT [4] = '{0, 0, 84, 21};

  typedef logic signed [FIELD_W-1:0] value_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  kwm_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  kwm_out_t out_data;

  kwm_in_t  beat_queue[$];
  kwm_out_t expected_results[$];
  value_t   list_q[LIST_COUNT][$];

  int   accepted_count = 0;
  int   total_beats = 0;
  int   fail_count = 0;
  int   idle_phase;
  logic hold_off = 1'b0;

  k_way_sorted_merge_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  always_comb begin
    idle_phase = (total_beats == 0) ? 0 : (accepted_count * 4) / total_beats;
    if (idle_phase > 3) idle_phase = 3;
  end

  // Applies one beat to the shadow lists and returns the result it must produce.
  function automatic kwm_out_t merge_step(kwm_in_t beat);
    kwm_out_t r;
    int       best;
    r = '0;
    best = -1;
    if (beat.operation == OP_PUSH) begin
      if (list_q[beat.list_index].size() >= LIST_DEPTH) r.status = ST_FULL;
      else list_q[beat.list_index] = {list_q[beat.list_index], beat.item_value};
    end else begin
      // On equal heads the higher list index wins.
      for (int k = 0; k < LIST_COUNT; k++) begin
        if (list_q[k].size() != 0 && (best < 0 || list_q[k][0] <= list_q[best][0])) best = k;
      end
      if (best < 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.merged_value = list_q[best].pop_front();
        r.source_list  = IDX_W'(best);
      end
    end
    return r;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  task automatic check_result(kwm_out_t got);
    kwm_out_t want;
    if (expected_results.size() == 0) begin
      note_failure($sformatf("unexpected beat value %0d list %0d status %0d",
                             got.merged_value, got.source_list, got.status));
      return;
    end
    want = expected_results.pop_front();
    if (got.merged_value !== want.merged_value)
      note_failure($sformatf("merged_value expected %0d got %0d",
                             want.merged_value, got.merged_value));
    if (got.source_list !== want.source_list)
      note_failure($sformatf("source_list expected %0d got %0d",
                             want.source_list, got.source_list));
    if (got.status !== want.status)
      note_failure($sformatf("status expected %0d got %0d", want.status, got.status));
  endtask

  task automatic queue_beat(logic op, int idx, longint val);
    kwm_in_t b;
    b.operation  = op;
    b.list_index = IDX_W'(idx);
    b.item_value = FIELD_W'(val);
    beat_queue = {beat_queue, b};
  endtask

  // Input side: a beat is offered, held until accepted, then the next one follows.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results = {expected_results, merge_step(in_data)};
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (beat_queue.size() != 0 && $urandom_range(99) >= SEND_IDLE_PCT[idle_phase]) begin
          in_data  <= beat_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: checks each accepted result and stalls at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      out_ready <= !hold_off && ($urandom_range(99) >= RECV_STALL_PCT[idle_phase]);
    end
  end

  // One long receiver hold-off while the sender keeps offering beats, so the core backs up.
  initial begin
    while (accepted_count < 40) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("k_way_sorted_merge_core regression: fail");
    $finish;
  end

  initial begin
    longint tail[LIST_COUNT];
    int     base_count;
    int     n_lists;
    int     first_list;
    int     push_total;
    int     lst;
    bit     narrow;

    // Directed: empty take, extremes, ties, ignored fields on take.
    queue_beat(OP_TAKE, 0, 0);
    queue_beat(OP_PUSH, 0, -64'sd2147483648);
    queue_beat(OP_PUSH, 7, 64'sd2147483647);
    queue_beat(OP_PUSH, 3, 0);
    queue_beat(OP_PUSH, 5, 0);
    queue_beat(OP_PUSH, 1, -1);
    queue_beat(OP_PUSH, 2, 64'sh55555555);
    queue_beat(OP_PUSH, 4, 64'shAAAAAAAA);
    queue_beat(OP_TAKE, 7, 64'shFFFFFFFF);
    queue_beat(OP_TAKE, 0, 0);
    queue_beat(OP_TAKE, 0, 0);
    queue_beat(OP_TAKE, 0, 0);
    queue_beat(OP_TAKE, 0, 0);
    queue_beat(OP_TAKE, 0, 0);
    queue_beat(OP_TAKE, 0, 0);
    queue_beat(OP_TAKE, 0, 0);
    // Both extremes tied across lists: the higher index must come out first.
    queue_beat(OP_PUSH, 0, -64'sd2147483648);
    queue_beat(OP_PUSH, 6, -64'sd2147483648);
    queue_beat(OP_PUSH, 2, 64'sd2147483647);
    queue_beat(OP_PUSH, 7, 64'sd2147483647);
    for (int i = 0; i < 5; i++) queue_beat(OP_TAKE, i, $urandom);

    // Fill one list past its depth, then drain it and take once more from empty.
    for (int i = 0; i < LIST_DEPTH + 3; i++) queue_beat(OP_PUSH, 6, i * 1000 - 30000);
    for (int i = 0; i < LIST_DEPTH + 1; i++) queue_beat(OP_TAKE, $urandom_range(0, 7), $urandom);

    base_count = beat_queue.size();
    while (beat_queue.size() - base_count < RANDOM_BEATS) begin
      if ($urandom_range(0, 9) < 7) begin
        // Ascending runs on a few lists with random content, then a drain.
        n_lists    = $urandom_range(1, LIST_COUNT);
        first_list = $urandom_range(0, LIST_COUNT - 1);
        narrow     = ($urandom_range(0, 2) == 0);
        for (int k = 0; k < LIST_COUNT; k++) begin
          if (narrow) tail[k] = longint'($urandom_range(0, 8)) - 4;
          else if ($urandom_range(0, 7) == 0) tail[k] = -64'sd2147483648;
          else tail[k] = longint'(value_t'($urandom));
        end
        push_total = $urandom_range(4, 24);
        for (int p = 0; p < push_total; p++) begin
          lst = (first_list + $urandom_range(0, n_lists - 1)) % LIST_COUNT;
          if (narrow) tail[lst] += $urandom_range(0, 2);
          else tail[lst] += $urandom_range(0, 1 << $urandom_range(0, 26));
          if (tail[lst] > 64'sd2147483647) tail[lst] = 64'sd2147483647;
          queue_beat(OP_PUSH, lst, tail[lst]);
          if ($urandom_range(0, 5) == 0) queue_beat(OP_TAKE, $urandom_range(0, 7), $urandom);
        end
        for (int t = 0; t < push_total; t++) queue_beat(OP_TAKE, $urandom_range(0, 7), $urandom);
      end else begin
        for (int n = $urandom_range(3, 12); n > 0; n--)
          queue_beat(1'($urandom_range(0, 1)), $urandom_range(0, 7), $urandom);
      end
    end
    total_beats = beat_queue.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (beat_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() != 0)
      $display("%0d results never arrived", expected_results.size());
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("k_way_sorted_merge_core regression: pass");
    end else begin
      $display("k_way_sorted_merge_core regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/kwm_pkg.sv
rtl/kwm_store.sv
rtl/kwm_cmp.sv
rtl/k_way_sorted_merge_core.sv
bench/tb_top.sv
